@@ design/ttv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed token validator package
// Type codes, running-state record and keyword tables shared by the checker
// and the top level.
// ----------------------------------------------------------------------------
package ttv_pkg;

    localparam int FUNC_W  = 4;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 4;
    localparam int ACC_W   = 17;
    localparam int KW_N    = 4;

    localparam logic [FUNC_W-1:0] FUNC_BYTE   = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_WORD   = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_DWORD  = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_STRING = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_INT    = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_BOOL   = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_DIGIT  = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_LETTER = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_FLAG   = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd11;
    localparam logic [ACC_W-1:0]   ACC_SAT   = 17'd65536;
    localparam logic [ACC_W-1:0]   BYTE_MAX  = 17'd255;

    localparam logic [COUNT_W-1:0] BYTE_MAX_LEN  = 4'd3;
    localparam logic [COUNT_W-1:0] WORD_MAX_LEN  = 4'd5;
    localparam logic [COUNT_W-1:0] DWORD_MAX_LEN = 4'd10;

    // Keyword slots: TRUE, FALSE, ON, OFF.
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_ON    = 2'd2;
    localparam logic [1:0] KW_OFF   = 2'd3;

    localparam logic [KW_N-1:0] KW_BOOL_MASK = 4'b0011;
    localparam logic [KW_N-1:0] KW_FLAG_MASK = 4'b1100;

    typedef struct packed {
        logic [COUNT_W-1:0] char_count;
        logic [ACC_W-1:0]   value_acc;
        logic               still_ok;
        logic [KW_N-1:0]    word_match;
    } ttv_state_t;

    localparam ttv_state_t STATE_RESET = '{
        char_count: '0,
        value_acc:  '0,
        still_ok:   1'b1,
        word_match: '1
    };

    function automatic logic [COUNT_W-1:0] kw_len(input logic [1:0] k);
        logic [COUNT_W-1:0] len;
        unique case (k)
            KW_TRUE:  len = 4'd4;
            KW_FALSE: len = 4'd5;
            KW_ON:    len = 4'd2;
            KW_OFF:   len = 4'd3;
            default:  len = 4'd0;
        endcase
        return len;
    endfunction

    // Character of a keyword at a position; zero past the end of the word.
    function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] k,
                                                  input logic [COUNT_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        ch = 8'h00;
        unique case (k)
            KW_TRUE:
            begin
                unique case (pos)
                    4'd0: ch = "T";
                    4'd1: ch = "R";
                    4'd2: ch = "U";
                    4'd3: ch = "E";
                    default: ch = 8'h00;
                endcase
            end
            KW_FALSE:
            begin
                unique case (pos)
                    4'd0: ch = "F";
                    4'd1: ch = "A";
                    4'd2: ch = "L";
                    4'd3: ch = "S";
                    4'd4: ch = "E";
                    default: ch = 8'h00;
                endcase
            end
            KW_ON:
            begin
                unique case (pos)
                    4'd0: ch = "O";
                    4'd1: ch = "N";
                    default: ch = 8'h00;
                endcase
            end
            KW_OFF:
            begin
                unique case (pos)
                    4'd0: ch = "O";
                    4'd1: ch = "F";
                    4'd2: ch = "F";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ design/ttv_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed token validator character checker
// Combinational update of the running token state for one beat and the
// verdict for a beat that ends the token.
// ----------------------------------------------------------------------------
module ttv_check
(
    input  wire ttv_pkg::ttv_state_t          state,
    input  wire logic [ttv_pkg::FUNC_W-1:0]   func,
    input  wire logic [ttv_pkg::CHAR_W-1:0]   char_code,
    input  wire logic                         empty_token,
    input  wire logic                         last,
    output ttv_pkg::ttv_state_t               state_next,
    output logic                              token_end,
    output logic                              verdict
);

    logic                          is_digit;
    logic                          is_letter;
    logic [ttv_pkg::CHAR_W-1:0]    upper_char;
    logic                          char_ok;
    logic [20:0]                   acc_mul;
    logic [ttv_pkg::KW_N-1:0]      kw_hit;
    ttv_pkg::ttv_state_t           upd;

    assign is_digit  = (char_code >= "0") && (char_code <= "9");
    assign is_letter = ((char_code >= "a") && (char_code <= "z")) ||
                       ((char_code >= "A") && (char_code <= "Z"));
    assign upper_char = ((char_code >= "a") && (char_code <= "z")) ?
                        char_code - 8'd32 : char_code;

    always_comb
    begin
        unique case (func)
            ttv_pkg::FUNC_BYTE, ttv_pkg::FUNC_WORD,
            ttv_pkg::FUNC_DWORD, ttv_pkg::FUNC_DIGIT:
                char_ok = is_digit;
            ttv_pkg::FUNC_INT:
                char_ok = is_digit || ((state.char_count == '0) &&
                          ((char_code == "+") || (char_code == "-")));
            ttv_pkg::FUNC_LETTER:
                char_ok = is_letter;
            ttv_pkg::FUNC_STRING, ttv_pkg::FUNC_BOOL, ttv_pkg::FUNC_FLAG:
                char_ok = 1'b1;
            default:
                char_ok = 1'b0;
        endcase
    end

    // acc * 10 + digit as two shifts and two adds.
    assign acc_mul = {1'b0, state.value_acc, 3'b000} + {3'b000, state.value_acc, 1'b0}
                   + {17'd0, char_code[3:0]};

    always_comb
    begin
        for (int k = 0; k < ttv_pkg::KW_N; k++)
        begin
            kw_hit[k] = (state.char_count < ttv_pkg::kw_len(2'(k))) &&
                        (upper_char == ttv_pkg::kw_char(2'(k), state.char_count));
        end
    end

    always_comb
    begin
        upd = state;
        if (!empty_token)
        begin
            upd.still_ok = state.still_ok && char_ok;
            if (is_digit)
            begin
                upd.value_acc = (acc_mul > 21'(ttv_pkg::ACC_SAT)) ?
                                ttv_pkg::ACC_SAT : acc_mul[ttv_pkg::ACC_W-1:0];
            end
            upd.word_match = state.word_match & kw_hit;
            if (state.char_count < ttv_pkg::COUNT_SAT)
            begin
                upd.char_count = state.char_count + 4'd1;
            end
        end
    end

    assign token_end  = empty_token || last;
    assign state_next = token_end ? ttv_pkg::STATE_RESET : upd;

    always_comb
    begin
        unique case (func)
            ttv_pkg::FUNC_BYTE:
                verdict = upd.still_ok && (upd.char_count <= ttv_pkg::BYTE_MAX_LEN) &&
                          (upd.value_acc <= ttv_pkg::BYTE_MAX);
            ttv_pkg::FUNC_WORD:
                verdict = upd.still_ok && (upd.char_count <= ttv_pkg::WORD_MAX_LEN) &&
                          !upd.value_acc[ttv_pkg::ACC_W-1];
            ttv_pkg::FUNC_DWORD:
                verdict = upd.still_ok && (upd.char_count <= ttv_pkg::DWORD_MAX_LEN);
            ttv_pkg::FUNC_STRING:
                verdict = 1'b1;
            ttv_pkg::FUNC_INT:
                verdict = upd.still_ok && (upd.char_count != '0);
            ttv_pkg::FUNC_BOOL:
                verdict = |(upd.word_match & ttv_pkg::KW_BOOL_MASK);
            ttv_pkg::FUNC_DIGIT, ttv_pkg::FUNC_LETTER:
                verdict = upd.still_ok;
            ttv_pkg::FUNC_FLAG:
                verdict = |(upd.word_match & ttv_pkg::KW_FLAG_MASK);
            default:
                verdict = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/typed_token_validator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed token validator unit
// Checks a command-line parameter, one character per beat, against its type.
// ----------------------------------------------------------------------------
// A token-ending beat's verdict passes from the input register to the result register.
// Throughput: one beat per cycle, set by the single input register feeding
// the checker; the input side stalls only when a token-ending beat waits for
// a result register that is still full and stalled.
// Reset: asynchronous, active low; clears both registers' valid flags and
// returns the running token state to its start values.
// ----------------------------------------------------------------------------
module typed_token_validator_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Token character channel.
    input  wire logic                       tok_valid,
    output logic                            tok_stall,
    input  wire logic [ttv_pkg::FUNC_W-1:0] func,
    input  wire logic [ttv_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       empty_token,
    input  wire logic                       last,
    // Verdict channel.
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic                            valid_res
);

    // Input register. It holds one beat while the checker works on it.
    logic                       in_valid_reg;
    logic [ttv_pkg::FUNC_W-1:0] in_func_reg;
    logic [ttv_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_empty_reg;
    logic                       in_last_reg;

    // Running token state, updated as each beat leaves the input register.
    ttv_pkg::ttv_state_t        state_reg;
    ttv_pkg::ttv_state_t        state_next;

    // Result register.
    logic                       out_valid_reg;
    logic                       out_verdict_reg;

    logic                       token_end;
    logic                       verdict;
    logic                       out_free;
    logic                       in_advance;
    logic                       tok_fire;

    ttv_check u_check
    (
        .state       (state_reg),
        .func        (in_func_reg),
        .char_code   (in_char_reg),
        .empty_token (in_empty_reg),
        .last        (in_last_reg),
        .state_next  (state_next),
        .token_end   (token_end),
        .verdict     (verdict)
    );

    // The result register can take a verdict when it is empty or its beat
    // leaves this cycle. A beat that does not end the token needs no room
    // there, so it always moves on.
    assign out_free   = !out_valid_reg || !res_stall;
    assign in_advance = in_valid_reg && (!token_end || out_free);
    assign tok_stall  = in_valid_reg && !in_advance;
    assign tok_fire   = tok_valid && !tok_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tok_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_fire)
        begin
            in_func_reg  <= func;
            in_char_reg  <= char_code;
            in_empty_reg <= empty_token;
            in_last_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttv_pkg::STATE_RESET;
        end
        else if (in_advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_advance && token_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && token_end)
        begin
            out_verdict_reg <= verdict;
        end
    end

    assign res_valid = out_valid_reg;
    assign valid_res = out_verdict_reg;

    // A token-ending beat leaves the running state at its start values.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_advance && token_end) |=> (state_reg == ttv_pkg::STATE_RESET))
        else $error("token state not cleared after token end");

    // The input register holds a beat only while a verdict waits downstream.
    a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_advance) |-> (out_valid_reg && res_stall && token_end))
        else $error("input register held without a stalled result");

    // A stalled verdict is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_stall) |-> !(in_advance && token_end))
        else $error("pending verdict overwritten");

    // A stall toward the token side always has a beat in the input register.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        tok_stall |-> in_valid_reg)
        else $error("token channel stalled with an empty input register");

endmodule
`default_nettype wire
